FILE: hdl/pte_pkg.sv
package pte_pkg;

   localparam int MAX_SIDE_DEF      = 2048;
   localparam int PALETTE_DEPTH_DEF = 256;

   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int PIXEL_ADDR_W = 22;
   localparam int PAL_INDEX_W  = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
   localparam logic       KIND_PIXEL   = 1'b1;

   typedef enum logic [1:0] {
      FMT_P8,
      FMT_P4,
      FMT_RGB888,
      FMT_RGBA8888
   } pte_format_type;

   typedef enum logic [1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_FORMAT
   } pte_csr_type;

   typedef enum logic [1:0] {
      OP_PAL_WRITE,
      OP_PIXEL_PAL,
      OP_PIXEL_DIRECT
   } pte_op_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pte_rgba_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] palette_slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] index_byte;
   } pte_req_type;

   typedef struct packed {
      logic [PIXEL_ADDR_W-1:0] pixel_address;
      logic [7:0]              out_red;
      logic [7:0]              out_green;
      logic [7:0]              out_blue;
      logic [7:0]              out_alpha;
      logic                    run_last;
      logic                    image_last;
   } pte_rsp_type;

   // one queued operation: a palette write or one output pixel
   typedef struct packed {
      pte_op_type             op;
      logic                   is_p4;
      logic                   run_last;
      logic [PAL_INDEX_W-1:0] pal_addr;
      pte_rgba_type           color;
   } pte_entry_type;

endpackage

FILE: hdl/pte_front.sv
module pte_front #(
   parameter int MAX_SIDE      = pte_pkg::MAX_SIDE_DEF,
   parameter int PALETTE_DEPTH = pte_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pte_pkg::pte_req_type                req_data,
   input  logic                                csr_write_en,
   input  logic [pte_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pte_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                q_full,
   output logic                                q_push,
   output pte_pkg::pte_entry_type              q_entry,
   output logic [$clog2(MAX_SIDE + 1)-1:0]     side_w,
   output logic [$clog2(MAX_SIDE + 1)-1:0]     side_h
);
   import pte_pkg::*;

   localparam int SW = $clog2(MAX_SIDE + 1);

   logic [CSR_DATA_W-1:0]  width_ff, width_in;
   logic [CSR_DATA_W-1:0]  height_ff, height_in;
   pte_format_type         format_ff, format_in;
   logic                   phase_ff, phase_in;

   logic [PAL_INDEX_W-1:0] slot_map [256];
   logic [PAL_INDEX_W-1:0] map_sel;
   logic                   is_pixel;
   logic                   is_p4;
   logic                   drop;

   // palette index wrap, folded into a constant table
   for (genvar gi = 0; gi < 256; gi++) begin : g_slot_map
      assign slot_map[gi] = PAL_INDEX_W'(gi % PALETTE_DEPTH);
   end

   function automatic logic [SW-1:0] clamp_side(input logic [CSR_DATA_W-1:0] v);
      logic [SW-1:0] res;
      if (v == '0) begin
         res = SW'(1);
      end else if ({1'b0, v} > (CSR_DATA_W + 1)'(MAX_SIDE)) begin
         res = SW'(MAX_SIDE);
      end else begin
         res = SW'(v);
      end
      return res;
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      format_in = format_ff;
      if (csr_write_en) begin
         case (pte_csr_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_FORMAT: format_in = pte_format_type'(csr_wdata[1:0]);
            default:    ;
         endcase
      end
   end

   always_comb begin
      side_w   = clamp_side(width_ff);
      side_h   = clamp_side(height_ff);
      is_pixel = (req_data.kind == KIND_PIXEL);
      is_p4    = is_pixel && (format_ff == FMT_P4);
      // a 1x1 image holds no pixel pair in P4
      drop     = is_p4 && (side_w == SW'(1)) && (side_h == SW'(1));
      map_sel  = is_pixel ? req_data.index_byte : req_data.palette_slot;

      q_entry.op          = OP_PIXEL_DIRECT;
      q_entry.is_p4       = is_p4;
      q_entry.run_last    = !is_p4 || phase_ff;
      q_entry.pal_addr    = slot_map[map_sel];
      q_entry.color.red   = req_data.red;
      q_entry.color.green = req_data.green;
      q_entry.color.blue  = req_data.blue;
      q_entry.color.alpha = req_data.alpha;

      if (!is_pixel) begin
         q_entry.op = OP_PAL_WRITE;
      end else begin
         case (format_ff)
            FMT_P8: begin
               q_entry.op = OP_PIXEL_PAL;
            end
            FMT_P4: begin
               q_entry.op       = OP_PIXEL_PAL;
               q_entry.pal_addr = phase_ff ? {4'b0, req_data.index_byte[7:4]}
                                           : {4'b0, req_data.index_byte[3:0]};
            end
            FMT_RGB888: begin
               q_entry.color.alpha = ALPHA_OPAQUE;
            end
            default: ;
         endcase
      end

      q_push    = req_valid && !drop && !q_full;
      req_ready = drop || (!q_full && (!is_p4 || phase_ff));

      phase_in = phase_ff;
      if (q_push && is_p4) begin
         phase_in = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(1);
         height_ff <= CSR_DATA_W'(1);
         format_ff <= FMT_P8;
         phase_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         format_ff <= format_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

FILE: hdl/pte_queue.sv
module pte_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pte_pkg::pte_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output pte_pkg::pte_entry_type head_entry
);
   import pte_pkg::*;

   pte_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   always_comb begin
      full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = entries_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: hdl/pte_back.sv
module pte_back #(
   parameter int MAX_SIDE      = pte_pkg::MAX_SIDE_DEF,
   parameter int PALETTE_DEPTH = pte_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  pte_pkg::pte_entry_type          q_entry,
   input  logic [$clog2(MAX_SIDE + 1)-1:0] side_w,
   input  logic [$clog2(MAX_SIDE + 1)-1:0] side_h,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pte_pkg::pte_rsp_type            rsp_data
);
   import pte_pkg::*;

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int CW = $clog2(MAX_SIDE);
   localparam int PW = CW + SW;
   localparam int AW = $clog2(PALETTE_DEPTH);

   pte_rgba_type   pal_mem [PALETTE_DEPTH];
   pte_rgba_type   pal_rd_ff;

   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  row_ff, row_in;

   logic           s1_valid_ff, s1_valid_in;
   logic [CW-1:0]  s1_row_ff, s1_row_in;
   logic [CW-1:0]  s1_col_ff;
   logic           s1_use_pal_ff;
   pte_rgba_type   s1_color_ff;
   logic           s1_run_last_ff;
   logic           s1_last_ff, s1_last_in;

   logic           rsp_valid_ff;
   pte_rsp_type    rsp_ff, rsp_in;

   logic           adv;
   logic           is_pix;
   logic           p4_odd;
   logic           restart;
   logic [SW-1:0]  wl;
   logic [SW-1:0]  hl;
   logic [CW-1:0]  c, r, c_n, r_n;
   logic [AW-1:0]  pal_addr;
   logic [PW-1:0]  addr_full;
   pte_rgba_type   color;

   // position step: restart check, flip, advance, end of image
   always_comb begin
      adv      = !rsp_valid_ff || rsp_ready;
      q_pop    = q_valid && adv;
      is_pix   = (q_entry.op != OP_PAL_WRITE);
      pal_addr = q_entry.pal_addr[AW-1:0];
      wl       = side_w - 1'b1;
      hl       = side_h - 1'b1;
      // P4 with an odd pixel count ends one pixel early
      p4_odd   = q_entry.is_p4 && side_w[0] && side_h[0];
      restart  = (SW'(col_ff) >= side_w) || (SW'(row_ff) >= side_h) ||
                 (p4_odd && (SW'(col_ff) == wl) && (SW'(row_ff) == hl));
      c        = restart ? '0 : col_ff;
      r        = restart ? '0 : row_ff;
      if (SW'(c) == wl) begin
         c_n = '0;
         r_n = r + 1'b1;
      end else begin
         c_n = c + 1'b1;
         r_n = r;
      end
      s1_last_in = p4_odd ? ((SW'(r_n) == hl) && (SW'(c_n) == wl))
                          : ((SW'(c) == wl) && (SW'(r) == hl));
      s1_row_in  = (q_entry.op == OP_PIXEL_PAL) ? CW'(hl - SW'(r)) : r;
      s1_valid_in = q_pop && is_pix;

      col_in = col_ff;
      row_in = row_ff;
      if (q_pop && is_pix) begin
         col_in = s1_last_in ? '0 : c_n;
         row_in = s1_last_in ? '0 : r_n;
      end
   end

   always_comb begin
      addr_full = PW'(s1_row_ff) * PW'(side_w) + PW'(s1_col_ff);
      color     = s1_use_pal_ff ? pal_rd_ff : s1_color_ff;
      rsp_in.pixel_address = PIXEL_ADDR_W'(addr_full);
      rsp_in.out_red       = color.red;
      rsp_in.out_green     = color.green;
      rsp_in.out_blue      = color.blue;
      rsp_in.out_alpha     = color.alpha;
      rsp_in.run_last      = s1_run_last_ff;
      rsp_in.image_last    = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            s1_valid_ff  <= s1_valid_in;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_row_ff      <= s1_row_in;
         s1_col_ff      <= c;
         s1_use_pal_ff  <= (q_entry.op == OP_PIXEL_PAL);
         s1_color_ff    <= q_entry.color;
         s1_run_last_ff <= q_entry.run_last;
         s1_last_ff     <= s1_last_in;
         rsp_ff         <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && !is_pix) begin
         pal_mem[pal_addr] <= q_entry.color;
      end
      if (adv) begin
         pal_rd_ff <= pal_mem[pal_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      q_pop && is_pix |=> (SW'(col_ff) < side_w) && (SW'(row_ff) < side_h))
      else $error("position left the image after a pixel");

   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop && is_pix && s1_last_in |=> (col_ff == '0) && (row_ff == '0))
      else $error("position not cleared after final pixel");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a stage-one pixel");

endmodule

FILE: hdl/palette_texture_expander_top.sv
// Palette texture expander.
// req channel: one beat per texture item. kind 0 loads one palette entry and
// gives no result; kind 1 is pixel data decoded by the format register.
// rsp channel: one beat per RGBA8 pixel with its destination address;
// run_last marks the last beat of an item, image_last the final pixel.
// csr port: width, height and format, to be written only while the block is
// idle; the user must keep to this, the block itself does not enforce it.
// Path of a result: queue write, palette read stage, output register. The
// queue write is the accepting edge, except for the first pixel of a P4 item,
// which is queued before the item is accepted with its second pixel's write.
// Throughput, while the queue is not full: one beat per cycle for P8, RGB888,
// RGBA8888 and palette loads; a P4 item pushes its pixels one at a time,
// limited by the single queue write and result port.
// Reset clears the position counters, the queue and the pipeline and sets
// the registers to 1x1 P8. The palette is not cleared; load it before use.
// When rsp_ready is low with a result valid the output holds and the back end
// stalls; the front keeps accepting until the queue fills.
module palette_texture_expander_top #(
   parameter int MAX_SIDE      = pte_pkg::MAX_SIDE_DEF,
   parameter int PALETTE_DEPTH = pte_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pte_pkg::pte_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pte_pkg::pte_rsp_type            rsp_data,
   input  logic                            csr_write_en,
   input  logic [pte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pte_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pte_pkg::*;

   localparam int SW = $clog2(MAX_SIDE + 1);

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_valid;
   pte_entry_type push_entry;
   pte_entry_type head_entry;
   logic [SW-1:0] side_w;
   logic [SW-1:0] side_h;

   pte_front #(
      .MAX_SIDE      (MAX_SIDE),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (push_entry),
      .side_w       (side_w),
      .side_h       (side_h)
   );

   pte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   pte_back #(
      .MAX_SIDE      (MAX_SIDE),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (head_entry),
      .side_w    (side_w),
      .side_h    (side_h),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
